FILE: src/thumbnail_box_downscaler_assert.svh
`ifndef THUMBNAIL_BOX_DOWNSCALER_ASSERT_SVH
`define THUMBNAIL_BOX_DOWNSCALER_ASSERT_SVH

// Checks b at the same edge as a, outside reset.
`define TBDS_ASSERT_SAME(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Checks b at the edge after a, outside reset.
`define TBDS_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

// Checks b at the edge after a, also while reset is high.
`define TBDS_ASSERT_NEXT_ALWAYS(label, clk, a, b, msg) \
   label: assert property (@(posedge clk) (a) |=> (b)) else $error(msg);

`endif

FILE: src/tbds_pkg.sv
package tbds_pkg;

   localparam int unsigned PIXEL_W     = 8;
   localparam int unsigned SIZE_W      = 13;
   localparam int unsigned SUM_W       = 12;
   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [SIZE_W-1:0] SOURCE_MAX   = 13'd4096;
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd1024;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd768;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 1'b1;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef logic [SIZE_W-1:0]  size_type;

endpackage

FILE: src/tbds_if.sv
interface tbds_req_if
   import tbds_pkg::*;
();
   logic      valid;
   logic      ready;
   pixel_type blue_in;
   pixel_type green_in;
   pixel_type red_in;

   modport source (output valid, output blue_in, output green_in, output red_in, input ready);
   modport sink (input valid, input blue_in, input green_in, input red_in, output ready);
endinterface

interface tbds_rsp_if
   import tbds_pkg::*;
();
   logic      valid;
   logic      ready;
   pixel_type blue_out;
   pixel_type green_out;
   pixel_type red_out;
   logic      thumb_last;

   modport source (output valid, output blue_out, output green_out, output red_out,
                   output thumb_last, input ready);
   modport sink (input valid, input blue_out, input green_out, input red_out,
                 input thumb_last, output ready);
endinterface

FILE: src/thumbnail_box_downscaler.sv
// Builds a THUMB_SIZE x THUMB_SIZE thumbnail from a BGR source frame that arrives one pixel
// per transaction in raster order; each thumbnail pixel is the truncated mean of 12 point
// samples (four columns by three rows) and leaves on the transaction that brings its last
// sample, in raster order, with thumb_last on the final pixel of the frame. Sample positions
// are tracked with exact integer error counters, and the sizes written through the csr port
// are clamped to 4*THUMB_SIZE..4096 columns and 3*THUMB_SIZE..4096 rows. The block takes one
// source pixel every cycle while ready is high; per-column sums live in a THUMB_SIZE-word
// memory that is read when a pixel is accepted and written back in the next cycle, with
// forwarding between neighboring pixels. Each result passes the stage register into a
// three-entry result queue that keeps ready high until three results wait untaken. The sums
// clear at once at reset and at the end of each frame through one flag per memory word.
module thumbnail_box_downscaler
   import tbds_pkg::*;
#(
   parameter int unsigned THUMB_SIZE = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_wdata,
   tbds_req_if.sink               req_port,
   tbds_rsp_if.source             rsp_port
);

   localparam int unsigned COL_SAMPLES = 4 * THUMB_SIZE;
   localparam int unsigned ROW_SAMPLES = 3 * THUMB_SIZE;
   localparam int unsigned X_W         = $clog2(THUMB_SIZE);
   localparam int unsigned XC_W        = $clog2(THUMB_SIZE + 1);
   localparam int unsigned POS_W       = SIZE_W - 1;
   localparam int unsigned FIFO_DEPTH  = 3;

   localparam size_type         COL_D       = SIZE_W'(COL_SAMPLES);
   localparam size_type         ROW_D       = SIZE_W'(ROW_SAMPLES);
   localparam size_type         WIDTH_INIT  = (WIDTH_RESET < COL_D) ? COL_D : WIDTH_RESET;
   localparam size_type         HEIGHT_INIT = (HEIGHT_RESET < ROW_D) ? ROW_D : HEIGHT_RESET;
   localparam logic [XC_W-1:0]  X_END       = XC_W'(THUMB_SIZE);
   localparam logic [XC_W-1:0]  X_LAST      = XC_W'(THUMB_SIZE - 1);
   localparam logic [1:0]       PHASE_COL_LAST = 2'd3;
   localparam logic [1:0]       PHASE_ROW_LAST = 2'd2;
   localparam logic [1:0]       FIFO_LAST   = 2'(FIFO_DEPTH - 1);

   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } sum_type;

   typedef struct packed {
      pixel_type blue;
      pixel_type green;
      pixel_type red;
   } pixel_set_type;

   typedef struct packed {
      logic          sample;
      logic          emit;
      logic          last;
      logic          wrap;
      logic [X_W-1:0] x;
      pixel_set_type px;
   } stage_type;

   typedef struct packed {
      pixel_type blue_out;
      pixel_type green_out;
      pixel_type red_out;
      logic      thumb_last;
   } result_type;

   function automatic size_type clamp_size(input size_type v, input size_type lo);
      size_type r;
      if (v < lo) begin
         r = lo;
      end else if (v > SOURCE_MAX) begin
         r = SOURCE_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Division by twelve: a shift by two and a reciprocal multiply for the divide by three.
   function automatic pixel_type div_twelve(input logic [SUM_W-1:0] v);
      logic [19:0] prod;
      prod = 20'(v[SUM_W-1:2]) * 20'd683;
      return prod[18:11];
   endfunction

   size_type            width_ff, width_in;
   size_type            height_ff, height_in;
   logic [POS_W-1:0]    col_ff, col_in;
   logic [POS_W-1:0]    row_ff, row_in;
   size_type            col_err_ff, col_err_in;
   size_type            row_err_ff, row_err_in;
   logic [XC_W-1:0]     samp_x_ff, samp_x_in;
   logic [XC_W-1:0]     samp_y_ff, samp_y_in;
   logic [1:0]          kph_ff, kph_in;
   logic [1:0]          jph_ff, jph_in;

   logic                accept;
   logic                col_hit;
   logic                row_hit;
   logic                row_end;
   logic                frame_end;
   logic [X_W-1:0]      x_addr;

   logic                s1_valid_ff, s1_valid_in;
   stage_type           s1_ff, s1_in;
   logic                fwd_hit_ff, fwd_hit_in;
   sum_type             fwd_sum_ff;
   sum_type             rd_data_ff;
   sum_type             sum_mem [THUMB_SIZE];
   logic [THUMB_SIZE-1:0] sum_valid_ff, sum_valid_in;

   sum_type             base_sum;
   sum_type             new_sum;
   sum_type             wr_sum;
   logic                mem_we;
   result_type          result;

   result_type          fifo_mem [FIFO_DEPTH];
   logic [1:0]          wr_ptr_ff, wr_ptr_in;
   logic [1:0]          rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push;
   logic                pop;
   logic [2:0]          pending;

   assign accept = req_port.valid && req_port.ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:  width_in  = clamp_size(csr_wdata, COL_D);
            CSR_SOURCE_HEIGHT: height_in = clamp_size(csr_wdata, ROW_D);
         endcase
      end
   end

   always_comb begin
      col_hit   = (samp_x_ff < X_END) && (col_err_ff < COL_D);
      row_hit   = (samp_y_ff < X_END) && (row_err_ff < ROW_D);
      row_end   = {1'b0, col_ff} >= (width_ff - SIZE_W'(1));
      frame_end = {1'b0, row_ff} >= (height_ff - SIZE_W'(1));
      x_addr    = samp_x_ff[X_W-1:0];

      s1_in.sample = row_hit && col_hit;
      s1_in.emit   = row_hit && col_hit && (kph_ff == PHASE_COL_LAST) &&
                     (jph_ff == PHASE_ROW_LAST);
      s1_in.last   = (samp_x_ff == X_LAST) && (samp_y_ff == X_LAST);
      s1_in.wrap   = row_end && frame_end;
      s1_in.x      = x_addr;
      s1_in.px     = '{blue: req_port.blue_in, green: req_port.green_in,
                       red: req_port.red_in};
      s1_valid_in  = accept;

      col_in     = col_ff;
      row_in     = row_ff;
      col_err_in = col_err_ff;
      row_err_in = row_err_ff;
      samp_x_in  = samp_x_ff;
      samp_y_in  = samp_y_ff;
      kph_in     = kph_ff;
      jph_in     = jph_ff;

      if (accept) begin
         if (col_hit) begin
            col_err_in = col_err_ff + width_ff - COL_D;
            if (kph_ff == PHASE_COL_LAST) begin
               kph_in    = '0;
               samp_x_in = samp_x_ff + XC_W'(1);
            end else begin
               kph_in = kph_ff + 2'd1;
            end
         end else if (samp_x_ff < X_END) begin
            col_err_in = col_err_ff - COL_D;
         end

         if (row_end) begin
            col_in     = '0;
            col_err_in = '0;
            samp_x_in  = '0;
            kph_in     = '0;
            if (row_hit) begin
               row_err_in = row_err_ff + height_ff - ROW_D;
               if (jph_ff == PHASE_ROW_LAST) begin
                  jph_in    = '0;
                  samp_y_in = samp_y_ff + XC_W'(1);
               end else begin
                  jph_in = jph_ff + 2'd1;
               end
            end else if (samp_y_ff < X_END) begin
               row_err_in = row_err_ff - ROW_D;
            end
            if (frame_end) begin
               row_in     = '0;
               row_err_in = '0;
               samp_y_in  = '0;
               jph_in     = '0;
            end else begin
               row_in = row_ff + POS_W'(1);
            end
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_INIT;
         height_ff   <= HEIGHT_INIT;
         col_ff      <= '0;
         row_ff      <= '0;
         col_err_ff  <= '0;
         row_err_ff  <= '0;
         samp_x_ff   <= '0;
         samp_y_ff   <= '0;
         kph_ff      <= '0;
         jph_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         col_err_ff  <= col_err_in;
         row_err_ff  <= row_err_in;
         samp_x_ff   <= samp_x_in;
         samp_y_ff   <= samp_y_in;
         kph_ff      <= kph_in;
         jph_ff      <= jph_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // A sum written back at the edge that reads the same word comes from the forward register.
   always_comb begin
      if (fwd_hit_ff) begin
         base_sum = fwd_sum_ff;
      end else if (sum_valid_ff[s1_ff.x]) begin
         base_sum = rd_data_ff;
      end else begin
         base_sum = '0;
      end
      new_sum.blue  = base_sum.blue + SUM_W'(s1_ff.px.blue);
      new_sum.green = base_sum.green + SUM_W'(s1_ff.px.green);
      new_sum.red   = base_sum.red + SUM_W'(s1_ff.px.red);
      wr_sum        = s1_ff.emit ? '0 : new_sum;
      mem_we        = s1_valid_ff && s1_ff.sample && !s1_ff.wrap;
      fwd_hit_in    = mem_we && (s1_ff.x == x_addr);

      result.blue_out   = div_twelve(new_sum.blue);
      result.green_out  = div_twelve(new_sum.green);
      result.red_out    = div_twelve(new_sum.red);
      result.thumb_last = s1_ff.last;

      sum_valid_in = sum_valid_ff;
      if (s1_valid_ff && s1_ff.wrap) begin
         sum_valid_in = '0;
      end else if (mem_we) begin
         sum_valid_in[s1_ff.x] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= s1_in;
         fwd_hit_ff <= fwd_hit_in;
         fwd_sum_ff <= wr_sum;
         rd_data_ff <= sum_mem[x_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[s1_ff.x] <= wr_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= '0;
      end else begin
         sum_valid_ff <= sum_valid_in;
      end
   end

   always_comb begin
      push      = s1_valid_ff && s1_ff.emit;
      pop       = rsp_port.valid && rsp_port.ready;
      pending   = {1'b0, count_ff} + 3'(push);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_LAST) ? 2'd0 : wr_ptr_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_LAST) ? 2'd0 : rd_ptr_ff + 2'd1;
      end
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= result;
      end
   end

   assign req_port.ready      = pending <= 3'(FIFO_DEPTH - 1);
   assign rsp_port.valid      = count_ff != 2'd0;
   assign rsp_port.blue_out   = fifo_mem[rd_ptr_ff].blue_out;
   assign rsp_port.green_out  = fifo_mem[rd_ptr_ff].green_out;
   assign rsp_port.red_out    = fifo_mem[rd_ptr_ff].red_out;
   assign rsp_port.thumb_last = fifo_mem[rd_ptr_ff].thumb_last;

endmodule

FILE: src/tbds_checker.sv
`include "thumbnail_box_downscaler_assert.svh"

module tbds_checker
   import tbds_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input pixel_type blue_out,
   input pixel_type green_out,
   input pixel_type red_out,
   input logic      thumb_last
);

   `TBDS_ASSERT_NEXT(rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped before its transaction")
   `TBDS_ASSERT_NEXT(rsp_payload_holds, clock, reset, rsp_valid && !rsp_ready, ($stable({blue_out, green_out, red_out, thumb_last})), "rsp payload changed while stalled")
   `TBDS_ASSERT_NEXT_ALWAYS(rsp_empty_after_reset, clock, reset, !rsp_valid, "rsp valid right after reset")
   `TBDS_ASSERT_SAME(rsp_needs_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a source pixel two cycles before")

endmodule

bind thumbnail_box_downscaler tbds_checker u_tbds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .blue_out   (rsp_port.blue_out),
   .green_out  (rsp_port.green_out),
   .red_out    (rsp_port.red_out),
   .thumb_last (rsp_port.thumb_last)
);
